// File: src/kms_pkg.sv
// Shared types and constants of the k-way merge selector.
// No dependencies; imported by kms_head_mem and kway_merge_selector.
package kms_pkg;

    localparam int RUNS      = 64;
    localparam int RUN_W     = 6;
    localparam int CNT_W     = 7;
    localparam int KEY_W     = 32;
    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 104;

    localparam logic [0:0] OP_LOAD = 1'b0;
    localparam logic [0:0] OP_POP  = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] count;
        logic [KEY_W-1:0] sec;
        logic [KEY_W-1:0] key;
    } head_rec_t;

endpackage

// File: src/kms_head_mem.sv
// Head record store: one synchronous RAM, one write and one read port.
// Depends on kms_pkg.
module kms_head_mem (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [kms_pkg::RUN_W-1:0]   wr_addr,
    input  kms_pkg::head_rec_t          wr_data,
    input  logic [kms_pkg::RUN_W-1:0]   rd_addr,
    output kms_pkg::head_rec_t          rd_data
);
    import kms_pkg::*;

    head_rec_t mem [RUNS];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// File: src/kway_merge_selector.sv
// Top level of the k-way merge selector: handshakes, valid marks, scan control.
// Depends on kms_pkg and kms_head_mem.
//
//  channel  | direction | tdata (low bit up)                        | tuser
//  s_       | in        | run, key, secondary_key, payload_count    | operation
//  m_       | out       | out_run, out_key, out_secondary_key, count| empty_res
//  cfg_     | in        | run_count                                 | -
//
// A pop reads the slots 0 .. min(run_count,64)-1 one per cycle from the head RAM
// (one read port, one comparator) and puts the selected head in the output register.
// Reset clears the valid marks and sets run_count to 64; RAM contents are kept.
// A finished pop waits in the last state while the output register is full.
module kway_merge_selector (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [kms_pkg::S_TDATA_W-1:0]    s_tdata,  // run, key, secondary_key, payload_count
    input  logic                             s_tuser,  // operation
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [kms_pkg::M_TDATA_W-1:0]    m_tdata,  // out_run, out_key, out_secondary_key, out_count
    output logic                             m_tuser,  // empty_res
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [kms_pkg::CNT_W-1:0]        cfg_data  // run_count
);
    import kms_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      run_count_reg, run_count_next;
    logic [RUNS-1:0]       valid_reg, valid_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    logic                  pend_reg, pend_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic [RUN_W-1:0]      pend_idx_reg, pend_idx_next;
    logic                  found_reg, found_next;
    logic [RUN_W-1:0]      best_idx_reg, best_idx_next;
    head_rec_t             best_reg, best_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  out_empty_reg, out_empty_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    logic [CNT_W-1:0]      limit;
    logic                  issue;
    logic                  s_xfer;
    logic                  wr_en;
    head_rec_t             wr_data;
    head_rec_t             rd_data;
    logic [RUN_W-1:0]      rd_addr;
    logic                  better;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_empty_reg;

    assign limit   = (run_count_reg > CNT_W'(RUNS)) ? CNT_W'(RUNS) : run_count_reg;
    assign issue   = (state_reg == ST_SCAN) && (rd_cnt_reg < limit);
    assign rd_addr = rd_cnt_reg[RUN_W-1:0];

    assign wr_en        = s_xfer && (s_tuser == OP_LOAD);
    assign wr_data.key   = s_tdata[RUN_W +: KEY_W];
    assign wr_data.sec   = s_tdata[RUN_W+KEY_W +: KEY_W];
    assign wr_data.count = s_tdata[RUN_W+2*KEY_W +: KEY_W];

    assign better = !found_reg || (rd_data.key < best_reg.key) ||
                    ((rd_data.key == best_reg.key) && (rd_data.sec < best_reg.sec));

    kms_head_mem u_head_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_tdata[RUN_W-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next     = state_reg;
        run_count_next = run_count_reg;
        valid_next     = valid_reg;
        rd_cnt_next    = rd_cnt_reg;
        pend_next      = 1'b0;
        pend_vld_next  = 1'b0;
        pend_idx_next  = rd_addr;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_next      = best_reg;
        out_vld_next   = out_vld_reg;
        out_empty_next = out_empty_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready) begin
            run_count_next = cfg_data;
        end
        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == OP_LOAD) begin
                        valid_next[s_tdata[RUN_W-1:0]] = 1'b1;
                    end else begin
                        rd_cnt_next = '0;
                        found_next  = 1'b0;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    pend_next     = 1'b1;
                    pend_vld_next = valid_reg[rd_addr];
                    rd_cnt_next   = rd_cnt_reg + CNT_W'(1);
                end
                if (pend_reg && pend_vld_reg && better) begin
                    found_next    = 1'b1;
                    best_idx_next = pend_idx_reg;
                    best_next     = rd_data;
                end
                if (!issue && !pend_reg) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!out_vld_reg || m_tready) begin
                    out_vld_next   = 1'b1;
                    out_empty_next = !found_reg;
                    if (found_reg) begin
                        out_data_next = {2'b00, best_reg.count, best_reg.sec,
                                         best_reg.key, best_idx_reg};
                        valid_next[best_idx_reg] = 1'b0;
                    end else begin
                        out_data_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            run_count_reg <= CNT_W'(RUNS);
            valid_reg     <= '0;
            pend_reg      <= 1'b0;
            out_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            run_count_reg <= run_count_next;
            valid_reg     <= valid_next;
            pend_reg      <= pend_next;
            out_vld_reg   <= out_vld_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_cnt_reg    <= rd_cnt_next;
        pend_vld_reg  <= pend_vld_next;
        pend_idx_reg  <= pend_idx_next;
        best_idx_reg  <= best_idx_next;
        best_reg      <= best_next;
        out_empty_reg <= out_empty_next;
        out_data_reg  <= out_data_next;
    end

endmodule
